[sv/mrv_pkg.sv]
package mrv_pkg;

  // payload widths
  localparam int AXIS_W = 13;
  localparam int ABS_W  = AXIS_W + 1;
  localparam int MEAN_W = 23;
  localparam int DEV_W  = 40;
  localparam int CNT_W  = 9;

  // fixed point and batch limits
  localparam int FRAC_W    = 16;
  localparam int MAX_PAIRS = 256;
  localparam int MAG_DIV   = 204;
  localparam int NUM_AXES  = 3;

  // shared shift-subtract unit
  localparam int SQ_W       = 2 * ABS_W;
  localparam int WORK_W     = 32;
  localparam int OP_W       = WORK_W + 2;
  localparam int ROOT_STEPS = SQ_W / 2 + FRAC_W;
  localparam int DIV_STEPS  = WORK_W;
  localparam int STEP_W     = 5;

  // shared multiplier
  localparam int MUL_A_W = WORK_W;
  localparam int MUL_B_W = MEAN_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // divide by 204 as root/4 times a rounded-up reciprocal of 51,
  // exact for every root/4 below 2^28
  localparam int MAG_SHIFT   = 2;
  localparam int MAG_ODD     = MAG_DIV >> MAG_SHIFT;
  localparam int RECIP_SHIFT = 34;
  localparam int RECIP_STEPS = 3;
  localparam int RECIP_W     = RECIP_SHIFT + MEAN_W + 1;
  localparam longint unsigned RECIP_MUL =
    ((64'd1 << RECIP_SHIFT) + MAG_ODD - 1) / MAG_ODD;
  localparam logic [MUL_B_W-1:0] RECIP_LO = MUL_B_W'(RECIP_MUL);
  localparam logic [MUL_B_W-1:0] RECIP_HI = MUL_B_W'(RECIP_MUL >> MUL_B_W);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_ROOT,
    S_DIVM,
    S_MUL_NO,
    S_DIVN_LD,
    S_DIVN,
    S_DIFF,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_ACC,
    S_UPD,
    S_EMIT
  } mrv_state_t;

endpackage

[sv/mrv_if.sv]
interface mrv_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [mrv_pkg::AXIS_W-1:0] first_x;
  logic signed [mrv_pkg::AXIS_W-1:0] first_y;
  logic signed [mrv_pkg::AXIS_W-1:0] first_z;
  logic signed [mrv_pkg::AXIS_W-1:0] second_x;
  logic signed [mrv_pkg::AXIS_W-1:0] second_y;
  logic signed [mrv_pkg::AXIS_W-1:0] second_z;
  logic                              batch_start;
  logic                              batch_end;

  modport source (
    output valid, first_x, first_y, first_z, second_x, second_y, second_z,
           batch_start, batch_end,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
           batch_start, batch_end,
    output ready
  );
endinterface

interface mrv_out_if;
  logic                        valid;
  logic                        ready;
  logic [mrv_pkg::DEV_W-1:0]   deviation_sum;
  logic [mrv_pkg::MEAN_W-1:0]  mean_magnitude;
  logic [mrv_pkg::CNT_W-1:0]   pairs_seen;
  logic                        overflowed;

  modport source (
    output valid, deviation_sum, mean_magnitude, pairs_seen, overflowed,
    input  ready
  );
  modport sink (
    input  valid, deviation_sum, mean_magnitude, pairs_seen, overflowed,
    output ready
  );
endinterface

[sv/accel_magnitude_running_variance.sv]
// Running mean and Welford deviation sum of accelerometer magnitude.
// in_item: one item holds two three-axis samples plus batch_start and
// batch_end flags; accepted when valid and ready are both high. ready is
// high only while the sequencer is idle.
// out_item: one result (deviation sum, mean, pair count, overflow flag)
// per item that has batch_end set, held in an output register until taken.
// Sequence: after acceptance an item passes through the axis squares,
// the square-root steps, the divide by 204 as a reciprocal multiply, the
// restoring divide for the mean update, and the multiplies and the state
// update.
// All long steps run through one shared compare-subtract unit and one
// 32x23 multiplier, so a new item is taken only once the sequencer is
// idle again, after any result has been loaded into the output register.
// A stalled receiver blocks the sequencer only when a new result is ready
// while the previous one is still waiting in the output register.
// Reset (synchronous, active low) clears count, mean, deviation sum and
// the overflow flag and empties the output register; batch_start clears
// the same state before its item is used.
module accel_magnitude_running_variance (
  input  logic      clk,
  input  logic      rst_n,
  mrv_in_if.sink    in_item,
  mrv_out_if.source out_item
);

  mrv_pkg::mrv_state_t state_r, state_nxt;

  logic [mrv_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic [mrv_pkg::ABS_W-1:0]  ax_r, ax_nxt, ay_r, ay_nxt, az_r, az_nxt;
  logic                       end_r, end_nxt;
  logic [mrv_pkg::WORK_W-1:0] acc_r, acc_nxt, quo_r, quo_nxt, src_r, src_nxt;
  logic [mrv_pkg::PROD_W-1:0] prod_r, prod_nxt, t_r, t_nxt;
  logic [mrv_pkg::MEAN_W-1:0] m_r, m_nxt, nw_r, nw_nxt;
  logic [mrv_pkg::MEAN_W-1:0] d1_r, d1_nxt, d2_r, d2_nxt;
  logic [mrv_pkg::MEAN_W-1:0] mean_r, mean_nxt;
  logic [mrv_pkg::DEV_W-1:0]  dev_r, dev_nxt;
  logic [mrv_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                       sat_r, sat_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [mrv_pkg::DEV_W-1:0]  out_dev_r, out_dev_nxt;
  logic [mrv_pkg::MEAN_W-1:0] out_mean_r, out_mean_nxt;
  logic [mrv_pkg::CNT_W-1:0]  out_pairs_r, out_pairs_nxt;
  logic                       out_ovf_r, out_ovf_nxt;

  // shared unit signals
  logic [mrv_pkg::OP_W-1:0]   op_a, op_b;
  logic [mrv_pkg::OP_W:0]     diff;
  logic                       ge;
  logic [mrv_pkg::WORK_W-1:0] rem_new, quo_step;
  logic [mrv_pkg::CNT_W-1:0]  divisor;
  logic [mrv_pkg::MEAN_W-1:0] quo_clamp;

  // multiplier operands
  logic [mrv_pkg::MUL_A_W-1:0] mul_a;
  logic [mrv_pkg::MUL_B_W-1:0] mul_b;

  // update arithmetic
  logic [mrv_pkg::DEV_W:0]     dev_sum;
  logic [mrv_pkg::RECIP_W-1:0] recip_sum;

  function automatic logic [mrv_pkg::ABS_W-1:0] abs_sum(
    input logic signed [mrv_pkg::AXIS_W-1:0] a,
    input logic signed [mrv_pkg::AXIS_W-1:0] b
  );
    logic signed [mrv_pkg::ABS_W-1:0] s;
    s = mrv_pkg::ABS_W'(a) + mrv_pkg::ABS_W'(b);
    abs_sum = s[mrv_pkg::ABS_W-1] ? mrv_pkg::ABS_W'(-s) : mrv_pkg::ABS_W'(s);
  endfunction

  // shared compare-subtract: root step or restoring divide step
  always_comb begin
    divisor = count_r + 1'b1;
    if (state_r == mrv_pkg::S_ROOT) begin
      op_a = {acc_r, src_r[mrv_pkg::SQ_W-1 -: 2]};
      op_b = {quo_r, 2'b01};
    end else begin
      op_a = {1'b0, acc_r, src_r[mrv_pkg::WORK_W-1]};
      op_b = {{(mrv_pkg::OP_W - mrv_pkg::CNT_W){1'b0}}, divisor};
    end
    diff      = {1'b0, op_a} - {1'b0, op_b};
    ge        = ~diff[mrv_pkg::OP_W];
    rem_new   = ge ? diff[mrv_pkg::WORK_W-1:0] : op_a[mrv_pkg::WORK_W-1:0];
    quo_step  = {quo_r[mrv_pkg::WORK_W-2:0], ge};
    quo_clamp = (|quo_step[mrv_pkg::WORK_W-1:mrv_pkg::MEAN_W]) ? '1
                                                               : quo_step[mrv_pkg::MEAN_W-1:0];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      mrv_pkg::S_SQ: begin
        unique case (cnt_r[1:0])
          2'd0: begin
            mul_a = mrv_pkg::MUL_A_W'(ax_r);
            mul_b = mrv_pkg::MUL_B_W'(ax_r);
          end
          2'd1: begin
            mul_a = mrv_pkg::MUL_A_W'(ay_r);
            mul_b = mrv_pkg::MUL_B_W'(ay_r);
          end
          2'd2: begin
            mul_a = mrv_pkg::MUL_A_W'(az_r);
            mul_b = mrv_pkg::MUL_B_W'(az_r);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      // root/4 times the low, then the high part of the reciprocal
      mrv_pkg::S_DIVM: begin
        mul_a = src_r >> mrv_pkg::MAG_SHIFT;
        mul_b = (cnt_r == '0) ? mrv_pkg::RECIP_LO : mrv_pkg::RECIP_HI;
      end
      mrv_pkg::S_MUL_NO: begin
        mul_a = mrv_pkg::MUL_A_W'(count_r);
        mul_b = mean_r;
      end
      mrv_pkg::S_MUL1: begin
        mul_a = mrv_pkg::MUL_A_W'(d1_r);
        mul_b = d1_r;
      end
      mrv_pkg::S_MUL2: begin
        mul_a = mrv_pkg::MUL_A_W'(count_r);
        mul_b = d2_r;
      end
      mrv_pkg::S_MUL3: begin
        mul_a = prod_r[mrv_pkg::MUL_A_W-1:0];
        mul_b = d2_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mrv_pkg::PROD_W'(mul_a) * mrv_pkg::PROD_W'(mul_b);
  end

  // sequencer: next state and datapath registers
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    az_nxt        = az_r;
    end_nxt       = end_r;
    acc_nxt       = acc_r;
    quo_nxt       = quo_r;
    src_nxt       = src_r;
    t_nxt         = t_r;
    m_nxt         = m_r;
    nw_nxt        = nw_r;
    d1_nxt        = d1_r;
    d2_nxt        = d2_r;
    mean_nxt      = mean_r;
    dev_nxt       = dev_r;
    count_nxt     = count_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_item.ready;
    out_dev_nxt   = out_dev_r;
    out_mean_nxt  = out_mean_r;
    out_pairs_nxt = out_pairs_r;
    out_ovf_nxt   = out_ovf_r;
    dev_sum       = {1'b0, dev_r}
                    + (mrv_pkg::DEV_W + 1)'(t_r[mrv_pkg::PROD_W-1:mrv_pkg::FRAC_W]);
    recip_sum     = mrv_pkg::RECIP_W'(t_r)
                    + (mrv_pkg::RECIP_W'(prod_r) << mrv_pkg::MUL_B_W);

    unique case (state_r)
      // take an item, clear the batch state on batch_start
      mrv_pkg::S_IDLE: begin
        if (in_item.valid) begin
          ax_nxt  = abs_sum(in_item.first_x, in_item.second_x);
          ay_nxt  = abs_sum(in_item.first_y, in_item.second_y);
          az_nxt  = abs_sum(in_item.first_z, in_item.second_z);
          end_nxt = in_item.batch_end;
          src_nxt = '0;
          cnt_nxt = '0;
          if (in_item.batch_start) begin
            count_nxt = '0;
            mean_nxt  = '0;
            dev_nxt   = '0;
            sat_nxt   = 1'b0;
          end
          state_nxt = mrv_pkg::S_SQ;
        end
      end
      // sum of axis squares, one product behind the multiplier
      mrv_pkg::S_SQ: begin
        if (cnt_r != '0) begin
          src_nxt = src_r + prod_r[mrv_pkg::WORK_W-1:0];
        end
        if (cnt_r == mrv_pkg::STEP_W'(mrv_pkg::NUM_AXES)) begin
          cnt_nxt   = '0;
          acc_nxt   = '0;
          quo_nxt   = '0;
          state_nxt = mrv_pkg::S_ROOT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      // one root bit per cycle, two radicand bits shifted in
      mrv_pkg::S_ROOT: begin
        acc_nxt = rem_new;
        quo_nxt = quo_step;
        src_nxt = src_r << 2;
        if (cnt_r == mrv_pkg::STEP_W'(mrv_pkg::ROOT_STEPS - 1)) begin
          src_nxt   = quo_step;
          acc_nxt   = '0;
          quo_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = mrv_pkg::S_DIVM;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      // magnitude = root / 204: low product kept, high product added shifted
      mrv_pkg::S_DIVM: begin
        if (cnt_r == mrv_pkg::STEP_W'(mrv_pkg::RECIP_STEPS - 1)) begin
          m_nxt     = recip_sum[mrv_pkg::RECIP_W-1] ? '1
                      : recip_sum[mrv_pkg::RECIP_W-2:mrv_pkg::RECIP_SHIFT];
          state_nxt = mrv_pkg::S_MUL_NO;
        end else begin
          if (cnt_r != '0) begin
            t_nxt = prod_r;
          end
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      mrv_pkg::S_MUL_NO: begin
        state_nxt = mrv_pkg::S_DIVN_LD;
      end
      // dividend n*old + m
      mrv_pkg::S_DIVN_LD: begin
        src_nxt   = prod_r[mrv_pkg::WORK_W-1:0] + mrv_pkg::WORK_W'(m_r);
        acc_nxt   = '0;
        quo_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = mrv_pkg::S_DIVN;
      end
      // new mean = (n*old + m) / (n+1)
      mrv_pkg::S_DIVN: begin
        acc_nxt = rem_new;
        quo_nxt = quo_step;
        src_nxt = src_r << 1;
        if (cnt_r == mrv_pkg::STEP_W'(mrv_pkg::DIV_STEPS - 1)) begin
          nw_nxt    = quo_clamp;
          state_nxt = mrv_pkg::S_DIFF;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      mrv_pkg::S_DIFF: begin
        d1_nxt    = (m_r >= nw_r) ? m_r - nw_r : nw_r - m_r;
        d2_nxt    = (nw_r >= mean_r) ? nw_r - mean_r : mean_r - nw_r;
        state_nxt = mrv_pkg::S_MUL1;
      end
      mrv_pkg::S_MUL1: begin
        state_nxt = mrv_pkg::S_MUL2;
      end
      mrv_pkg::S_MUL2: begin
        t_nxt     = prod_r;
        state_nxt = mrv_pkg::S_MUL3;
      end
      mrv_pkg::S_MUL3: begin
        state_nxt = mrv_pkg::S_ACC;
      end
      mrv_pkg::S_ACC: begin
        t_nxt     = t_r + prod_r;
        state_nxt = mrv_pkg::S_UPD;
      end
      // commit mean, saturating deviation sum and count
      mrv_pkg::S_UPD: begin
        mean_nxt = nw_r;
        if (dev_sum[mrv_pkg::DEV_W]) begin
          dev_nxt = '1;
          sat_nxt = 1'b1;
        end else begin
          dev_nxt = dev_sum[mrv_pkg::DEV_W-1:0];
        end
        if (count_r >= mrv_pkg::CNT_W'(mrv_pkg::MAX_PAIRS)) begin
          sat_nxt = 1'b1;
        end else begin
          count_nxt = count_r + 1'b1;
        end
        state_nxt = end_r ? mrv_pkg::S_EMIT : mrv_pkg::S_IDLE;
      end
      // load the output register once it is free
      mrv_pkg::S_EMIT: begin
        if (!out_valid_r || out_item.ready) begin
          out_valid_nxt = 1'b1;
          out_dev_nxt   = dev_r;
          out_mean_nxt  = mean_r;
          out_pairs_nxt = count_r;
          out_ovf_nxt   = sat_r;
          state_nxt     = mrv_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mrv_pkg::S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrv_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control and batch state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      mean_r      <= '0;
      dev_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      count_r     <= count_nxt;
      mean_r      <= mean_nxt;
      dev_r       <= dev_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ax_r        <= ax_nxt;
    ay_r        <= ay_nxt;
    az_r        <= az_nxt;
    end_r       <= end_nxt;
    acc_r       <= acc_nxt;
    quo_r       <= quo_nxt;
    src_r       <= src_nxt;
    prod_r      <= prod_nxt;
    t_r         <= t_nxt;
    m_r         <= m_nxt;
    nw_r        <= nw_nxt;
    d1_r        <= d1_nxt;
    d2_r        <= d2_nxt;
    out_dev_r   <= out_dev_nxt;
    out_mean_r  <= out_mean_nxt;
    out_pairs_r <= out_pairs_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // ports
  assign in_item.ready           = (state_r == mrv_pkg::S_IDLE);
  assign out_item.valid          = out_valid_r;
  assign out_item.deviation_sum  = out_dev_r;
  assign out_item.mean_magnitude = out_mean_r;
  assign out_item.pairs_seen     = out_pairs_r;
  assign out_item.overflowed     = out_ovf_r;

endmodule
